// ----- hw/rtl/psa_pkg.sv -----
// Shared types and constants for the packed SIMD ALU.
package psa_pkg;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SADD = 4'd1,
        OP_UADD = 4'd2,
        OP_SUB  = 4'd3,
        OP_SSUB = 4'd4,
        OP_USUB = 4'd5,
        OP_EQ   = 4'd6,
        OP_GT   = 4'd7,
        OP_ABS  = 4'd8,
        OP_AND  = 4'd9,
        OP_XOR  = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        LW_BYTE = 2'd0,
        LW_HALF = 2'd1,
        LW_WORD = 2'd2
    } lane_w_t;

    localparam int unsigned DATA_W = 128;
    localparam int unsigned HALF_W = 64;

    typedef struct packed {
        logic    valid;
        mode_t   mode;
        lane_w_t lw;
        logic    illegal;
    } ctrl_t;

endpackage

// ----- hw/rtl/psa_req_if.sv -----
// Request channel: operation, lane width and both operands.
interface psa_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mode;
    logic [1:0]  lane_width;
    logic [63:0] operand_a_low;
    logic [63:0] operand_a_high;
    logic [63:0] operand_b_low;
    logic [63:0] operand_b_high;

    modport source (
        output valid, mode, lane_width,
        output operand_a_low, operand_a_high, operand_b_low, operand_b_high,
        input  ready
    );
    modport sink (
        input  valid, mode, lane_width,
        input  operand_a_low, operand_a_high, operand_b_low, operand_b_high,
        output ready
    );
endinterface

// ----- hw/rtl/psa_rsp_if.sv -----
// Response channel: packed result and illegal flag.
interface psa_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        illegal;

    modport source (
        output valid, result_low, result_high, illegal,
        input  ready
    );
    modport sink (
        input  valid, result_low, result_high, illegal,
        output ready
    );
endinterface

// ----- hw/rtl/psa_decode.sv -----
// Stage 1: decode of mode and lane width, operand capture.
module psa_decode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [3:0]                   mode,
    input  logic [1:0]                   lane_width,
    input  logic [psa_pkg::DATA_W-1:0]   a,
    input  logic [psa_pkg::DATA_W-1:0]   b,
    input  logic                         down_ready,
    output logic                         ready,
    output psa_pkg::ctrl_t               ctrl,
    output logic [psa_pkg::DATA_W-1:0]   a_out,
    output logic [psa_pkg::DATA_W-1:0]   b_out
);

    psa_pkg::ctrl_t               ctrl_reg;
    psa_pkg::ctrl_t               ctrl_next;
    logic [psa_pkg::DATA_W-1:0]   a_reg;
    logic [psa_pkg::DATA_W-1:0]   b_reg;
    logic [psa_pkg::DATA_W-1:0]   a_next;
    logic                         lw_ok;
    logic                         bad;

    assign ready = !ctrl_reg.valid || down_ready;

    always_comb
    begin
        case (psa_pkg::lane_w_t'(lane_width))
            psa_pkg::LW_BYTE: lw_ok = 1'b1;
            psa_pkg::LW_HALF: lw_ok = 1'b1;
            psa_pkg::LW_WORD: lw_ok = 1'b1;
            default:          lw_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        case (psa_pkg::mode_t'(mode))
            psa_pkg::OP_AND,
            psa_pkg::OP_XOR:  bad = 1'b0;
            psa_pkg::OP_ADD,
            psa_pkg::OP_SADD,
            psa_pkg::OP_UADD,
            psa_pkg::OP_SUB,
            psa_pkg::OP_SSUB,
            psa_pkg::OP_USUB,
            psa_pkg::OP_EQ,
            psa_pkg::OP_GT:   bad = !lw_ok;
            psa_pkg::OP_ABS:  bad = !lw_ok
                                    || (psa_pkg::lane_w_t'(lane_width) == psa_pkg::LW_BYTE);
            default:          bad = 1'b1;
        endcase
    end

    always_comb
    begin
        ctrl_next.valid   = in_valid;
        ctrl_next.mode    = psa_pkg::mode_t'(mode);
        ctrl_next.lw      = psa_pkg::lane_w_t'(lane_width);
        ctrl_next.illegal = bad;
        // abs works as 0 - b, so a is forced to zero
        a_next = (psa_pkg::mode_t'(mode) == psa_pkg::OP_ABS) ? '0 : a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (ready)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && in_valid)
        begin
            a_reg <= a_next;
            b_reg <= b;
        end
    end

    assign ctrl  = ctrl_reg;
    assign a_out = a_reg;
    assign b_out = b_reg;

endmodule

// ----- hw/rtl/psa_lane.sv -----
// One lane: registered widened sum and difference, then saturation and compare.
module psa_lane #(
    parameter int unsigned W = 8
) (
    input  logic            clk,
    input  logic            load,
    input  logic [W-1:0]    x,
    input  logic [W-1:0]    y,
    input  psa_pkg::mode_t  op,
    output logic [W-1:0]    r
);

    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    logic [W:0] sum_reg;
    logic [W:0] diff_reg;
    logic       xs_reg;
    logic       ys_reg;
    logic       eq_reg;
    logic       add_ovf;
    logic       sub_ovf;
    logic       lt;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg  <= {1'b0, x} + {1'b0, y};
            diff_reg <= {1'b0, x} - {1'b0, y};
            xs_reg   <= x[W-1];
            ys_reg   <= y[W-1];
            eq_reg   <= (x == y);
        end
    end

    always_comb
    begin
        add_ovf = (xs_reg == ys_reg) && (sum_reg[W-1] != xs_reg);
        sub_ovf = (xs_reg != ys_reg) && (diff_reg[W-1] != xs_reg);
        lt      = diff_reg[W-1] ^ sub_ovf;
        case (op)
            psa_pkg::OP_ADD:  r = sum_reg[W-1:0];
            psa_pkg::OP_SADD: r = add_ovf ? (xs_reg ? SMIN : SMAX) : sum_reg[W-1:0];
            psa_pkg::OP_UADD: r = sum_reg[W] ? '1 : sum_reg[W-1:0];
            psa_pkg::OP_SUB:  r = diff_reg[W-1:0];
            psa_pkg::OP_SSUB: r = sub_ovf ? (xs_reg ? SMIN : SMAX) : diff_reg[W-1:0];
            psa_pkg::OP_USUB: r = diff_reg[W] ? '0 : diff_reg[W-1:0];
            psa_pkg::OP_EQ:   r = eq_reg ? '1 : '0;
            psa_pkg::OP_GT:   r = (!lt && !eq_reg) ? '1 : '0;
            // x is zero here: sum is b, diff is -b; -MIN saturates to MAX
            psa_pkg::OP_ABS:  r = ys_reg ? (diff_reg[W-1] ? SMAX : diff_reg[W-1:0])
                                         : sum_reg[W-1:0];
            default:          r = '0;
        endcase
    end

endmodule

// ----- hw/rtl/psa_merge.sv -----
// Stage 3: logic or lane width result selection, illegal masking and output register.
module psa_merge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  psa_pkg::ctrl_t               ctrl,
    input  logic [psa_pkg::DATA_W-1:0]   logic_word,
    input  logic [psa_pkg::DATA_W-1:0]   r8,
    input  logic [psa_pkg::DATA_W-1:0]   r16,
    input  logic [psa_pkg::DATA_W-1:0]   r32,
    input  logic                         out_ready,
    output logic                         ready,
    output logic                         out_valid,
    output logic [psa_pkg::HALF_W-1:0]   result_low,
    output logic [psa_pkg::HALF_W-1:0]   result_high,
    output logic                         illegal
);

    logic                         valid_reg;
    logic [psa_pkg::DATA_W-1:0]   res_reg;
    logic [psa_pkg::DATA_W-1:0]   res_next;
    logic                         illegal_reg;

    assign ready = !valid_reg || out_ready;

    always_comb
    begin
        if (ctrl.illegal)
        begin
            res_next = '0;
        end
        else if ((ctrl.mode == psa_pkg::OP_AND) || (ctrl.mode == psa_pkg::OP_XOR))
        begin
            res_next = logic_word;
        end
        else
        begin
            case (ctrl.lw)
                psa_pkg::LW_BYTE: res_next = r8;
                psa_pkg::LW_HALF: res_next = r16;
                psa_pkg::LW_WORD: res_next = r32;
                default:          res_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && ctrl.valid)
        begin
            res_reg     <= res_next;
            illegal_reg <= ctrl.illegal;
        end
    end

    assign out_valid   = valid_reg;
    assign result_low  = res_reg[psa_pkg::HALF_W-1:0];
    assign result_high = res_reg[psa_pkg::DATA_W-1:psa_pkg::HALF_W];
    assign illegal     = illegal_reg;

endmodule

// ----- hw/rtl/packed_simd_alu_128_unit.sv -----
// Top level of the 128-bit packed SIMD ALU.
// An accepted item passes the registered stages decode, lane add and select on its way to rsp.
// Throughput: one item per cycle while rsp is not stalled; each stage advances when the next one is free or draining.
// A stalled rsp holds every occupied stage with no empty stage after it; empty stages still fill.
// Reset (rst_n, asynchronous, active low) clears the valid bit of every stage.
module packed_simd_alu_128_unit (
    input  logic        clk,
    input  logic        rst_n,
    psa_req_if.sink     req,
    psa_rsp_if.source   rsp
);

    psa_pkg::ctrl_t               ctrl1;
    logic [psa_pkg::DATA_W-1:0]   a1;
    logic [psa_pkg::DATA_W-1:0]   b1;
    psa_pkg::ctrl_t               ctrl2_reg;
    logic [psa_pkg::DATA_W-1:0]   logic2_reg;
    logic                         ready2;
    logic                         ready3;
    logic                         load2;
    logic [psa_pkg::DATA_W-1:0]   r8;
    logic [psa_pkg::DATA_W-1:0]   r16;
    logic [psa_pkg::DATA_W-1:0]   r32;

    psa_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .mode       (req.mode),
        .lane_width (req.lane_width),
        .a          ({req.operand_a_high, req.operand_a_low}),
        .b          ({req.operand_b_high, req.operand_b_low}),
        .down_ready (ready2),
        .ready      (req.ready),
        .ctrl       (ctrl1),
        .a_out      (a1),
        .b_out      (b1)
    );

    assign ready2 = !ctrl2_reg.valid || ready3;
    assign load2  = ready2 && ctrl1.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl2_reg <= '0;
        end
        else if (ready2)
        begin
            ctrl2_reg <= ctrl1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            logic2_reg <= (ctrl1.mode == psa_pkg::OP_AND) ? (a1 & b1) : (a1 ^ b1);
        end
    end

    for (genvar i = 0; i < psa_pkg::DATA_W / 8; i++)
    begin : g_byte
        psa_lane #(.W(8)) u_lane (
            .clk  (clk),
            .load (load2),
            .x    (a1[i*8 +: 8]),
            .y    (b1[i*8 +: 8]),
            .op   (ctrl2_reg.mode),
            .r    (r8[i*8 +: 8])
        );
    end

    for (genvar i = 0; i < psa_pkg::DATA_W / 16; i++)
    begin : g_half
        psa_lane #(.W(16)) u_lane (
            .clk  (clk),
            .load (load2),
            .x    (a1[i*16 +: 16]),
            .y    (b1[i*16 +: 16]),
            .op   (ctrl2_reg.mode),
            .r    (r16[i*16 +: 16])
        );
    end

    for (genvar i = 0; i < psa_pkg::DATA_W / 32; i++)
    begin : g_word
        psa_lane #(.W(32)) u_lane (
            .clk  (clk),
            .load (load2),
            .x    (a1[i*32 +: 32]),
            .y    (b1[i*32 +: 32]),
            .op   (ctrl2_reg.mode),
            .r    (r32[i*32 +: 32])
        );
    end

    psa_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl2_reg),
        .logic_word  (logic2_reg),
        .r8          (r8),
        .r16         (r16),
        .r32         (r32),
        .out_ready   (rsp.ready),
        .ready       (ready3),
        .out_valid   (rsp.valid),
        .result_low  (rsp.result_low),
        .result_high (rsp.result_high),
        .illegal     (rsp.illegal)
    );

    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.illegal |-> (rsp.result_low == '0) && (rsp.result_high == '0))
        else $error("illegal item with nonzero result");

    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl2_reg.valid && rsp.valid && !rsp.ready |=> ctrl2_reg.valid && $stable(ctrl2_reg))
        else $error("stage 2 item lost under stall");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> ctrl1.valid && ctrl2_reg.valid && rsp.valid && !rsp.ready)
        else $error("input stalled with a free stage");

    a_stage3_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl2_reg.valid && ready3 |=> rsp.valid)
        else $error("stage 2 item not moved to output");

endmodule
